/* rtl/biou_pkg.sv */
// Shared types and constants for the box IoU core.
// Holds the input and output word layouts and the divider flag bundle.
// No dependencies.
package biou_pkg;

	localparam int IN_W    = 16;	// width of one coordinate field
	localparam int RATIO_W = 16;	// width of the ratio field and number of divide steps

	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

	typedef logic signed [IN_W-1:0] coord_t;

	typedef struct packed {
		coord_t a_top;
		coord_t a_left;
		coord_t a_bottom;
		coord_t a_right;
		coord_t b_top;
		coord_t b_left;
		coord_t b_bottom;
		coord_t b_right;
	} box_word_t;

	typedef struct packed {
		logic [RATIO_W-1:0] overlap_ratio;
		logic               empty_union;
	} iou_word_t;

	typedef struct packed {
		logic empty;	// union <= 0
		logic sat;	// quotient does not fit in RATIO_W bits
	} div_flags_t;

endpackage

/* rtl/box_iou_pairwise_core.sv */
// Pairwise box IoU core: takes one pair of boxes (Q11.4 corners) per clock and
// returns intersection/union as unsigned Q0.16, saturated, with empty_union set
// and ratio 0 when the union is zero or negative. Sustained rate is one pair per
// cycle while box_stall is low; a result passes through three geometry stages,
// one divider setup stage, a 16-stage restoring divider (one quotient bit per
// stage) and the output register. The output register plus a one-word skid buffer
// absorb iou_stall; box_stall comes straight from a flop. Depends on biou_pkg.
module box_iou_pairwise_core #(
	parameter int COORD_BITS      = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                box_valid,
	output logic                box_stall,
	input  biou_pkg::box_word_t box,
	output logic                iou_valid,
	input  logic                iou_stall,
	output biou_pkg::iou_word_t iou
);
	import biou_pkg::*;

	localparam int UW = 2*COORD_BITS + 4;
	localparam int PW = 2*COORD_BITS;

	logic                 en;
	logic                 geom_valid;
	logic signed [UW-1:0] geom_uni;
	logic [PW-1:0]        geom_inter;
	logic                 div_valid;
	iou_word_t            div_word;
	logic                 arrive;

	logic      iou_valid_q, skid_valid_q;
	iou_word_t iou_q, skid_q;

	// whole pipeline holds only while the skid word is occupied
	assign en        = !skid_valid_q;
	assign box_stall = skid_valid_q;
	assign arrive    = en && div_valid;

	biou_geom #(
		.COORD_BITS(COORD_BITS)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.box_valid (box_valid),
		.box       (box),
		.valid_s3  (geom_valid),
		.uni_s3    (geom_uni),
		.inter_s3  (geom_inter)
	);

	biou_div #(
		.COORD_BITS      (COORD_BITS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (geom_valid),
		.uni_in    (geom_uni),
		.inter_in  (geom_inter),
		.valid_out (div_valid),
		.result    (div_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!iou_valid_q || !iou_stall) begin
			if (skid_valid_q) begin
				iou_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				iou_valid_q <= arrive;
			end
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!iou_valid_q || !iou_stall) begin
			if (skid_valid_q) begin
				iou_q <= skid_q;
			end else if (arrive) begin
				iou_q <= div_word;
			end
		end else if (arrive) begin
			skid_q <= div_word;
		end
	end

	assign iou_valid = iou_valid_q;
	assign iou       = iou_q;

endmodule

/* rtl/biou_geom.sv */
// Geometry front end: edge differences, areas, intersection and union.
// Three register stages (_s1.._s3). Depends on biou_pkg.
module biou_geom #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          box_valid,
	input  biou_pkg::box_word_t           box,
	output logic                          valid_s3,
	output logic signed [2*COORD_BITS+3:0] uni_s3,
	output logic [2*COORD_BITS-1:0]       inter_s3
);
	import biou_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int AW = 2*COORD_BITS + 2;
	localparam int PW = 2*COORD_BITS;
	localparam int UW = 2*COORD_BITS + 4;

	// Keep the low COORD_BITS bits of a field as two's complement; wider
	// settings see the 16-bit field zero-extended.
	function automatic logic signed [CW-1:0] coord(input logic [IN_W-1:0] raw);
		logic [IN_W+CW-1:0] ext;
		ext = (IN_W+CW)'(raw);
		return ext[CW-1:0];
	endfunction

	logic signed [CW-1:0] at, al, ab, ar, bt, bl, bb, br;
	logic signed [CW-1:0] top_i, left_i, bot_i, right_i;

	always_comb begin
		at = coord(box.a_top);
		al = coord(box.a_left);
		ab = coord(box.a_bottom);
		ar = coord(box.a_right);
		bt = coord(box.b_top);
		bl = coord(box.b_left);
		bb = coord(box.b_bottom);
		br = coord(box.b_right);
		top_i   = (at > bt) ? at : bt;
		left_i  = (al > bl) ? al : bl;
		bot_i   = (ab < bb) ? ab : bb;
		right_i = (ar < br) ? ar : br;
	end

	// stage 1: extents
	logic               valid_s1;
	logic signed [CW:0] ah_s1, aw_s1, bh_s1, bw_s1, ih_s1, iw_s1;

	// stage 2: products
	logic                 valid_s2;
	logic signed [AW-1:0] area_a_s2, area_b_s2;
	logic [PW-1:0]        inter_s2;

	logic [CW-1:0] ihc, iwc;

	// negative intersection extents clamp to zero
	assign ihc = ih_s1[CW] ? '0 : ih_s1[CW-1:0];
	assign iwc = iw_s1[CW] ? '0 : iw_s1[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= box_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ah_s1 <= (CW+1)'(ab) - (CW+1)'(at);
			aw_s1 <= (CW+1)'(ar) - (CW+1)'(al);
			bh_s1 <= (CW+1)'(bb) - (CW+1)'(bt);
			bw_s1 <= (CW+1)'(br) - (CW+1)'(bl);
			ih_s1 <= (CW+1)'(bot_i) - (CW+1)'(top_i);
			iw_s1 <= (CW+1)'(right_i) - (CW+1)'(left_i);

			area_a_s2 <= ah_s1 * aw_s1;
			area_b_s2 <= bh_s1 * bw_s1;
			inter_s2  <= iwc * ihc;

			uni_s3   <= UW'(area_a_s2) + UW'(area_b_s2) - signed'({4'b0000, inter_s2});
			inter_s3 <= inter_s2;
		end
	end

endmodule

/* rtl/biou_div_step.sv */
// One registered restoring-division step: one quotient bit per stage.
// Carries divisor, remaining dividend bits and flags alongside. Depends on biou_pkg.
module biou_div_step #(
	parameter int RW = 36
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  logic [RW-1:0]             rem_in,
	input  logic [RW-1:0]             dvs_in,
	input  logic [biou_pkg::RATIO_W-1:0] low_in,
	input  logic [biou_pkg::RATIO_W-1:0] quo_in,
	input  biou_pkg::div_flags_t      flags_in,
	output logic                      valid_sn,
	output logic [RW-1:0]             rem_sn,
	output logic [RW-1:0]             dvs_sn,
	output logic [biou_pkg::RATIO_W-1:0] low_sn,
	output logic [biou_pkg::RATIO_W-1:0] quo_sn,
	output biou_pkg::div_flags_t      flags_sn
);
	import biou_pkg::*;

	logic [RW:0] trial, diff;
	logic        ge;

	always_comb begin
		trial = {rem_in, low_in[RATIO_W-1]};
		diff  = trial - {1'b0, dvs_in};
		ge    = trial >= {1'b0, dvs_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn   <= ge ? diff[RW-1:0] : trial[RW-1:0];
			dvs_sn   <= dvs_in;
			low_sn   <= {low_in[RATIO_W-2:0], 1'b0};
			quo_sn   <= {quo_in[RATIO_W-2:0], ge};
			flags_sn <= flags_in;
		end
	end

endmodule

/* rtl/biou_div.sv */
// Pipelined divider: floor(inter * 2^RATIO_FRAC_BITS / union), saturated.
// One setup stage (_s4) then RATIO_W biou_div_step stages. Depends on biou_pkg.
module biou_div #(
	parameter int COORD_BITS      = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           valid_in,
	input  logic signed [2*COORD_BITS+3:0] uni_in,
	input  logic [2*COORD_BITS-1:0]        inter_in,
	output logic                           valid_out,
	output biou_pkg::iou_word_t            result
);
	import biou_pkg::*;

	localparam int RW = 2*COORD_BITS + 4;
	localparam int NW = 2*COORD_BITS + RATIO_FRAC_BITS;
	localparam int XW = (NW > RW + RATIO_W) ? NW : RW + RATIO_W;
	localparam int HW = XW - RATIO_W;

	logic [XW-1:0] num;
	logic [HW-1:0] num_hi, dvs_ext;
	div_flags_t    flags_d;

	always_comb begin
		num     = XW'(inter_in) << RATIO_FRAC_BITS;
		num_hi  = num[XW-1:RATIO_W];
		dvs_ext = HW'(unsigned'(uni_in));
		flags_d.empty = uni_in[RW-1] || (uni_in == '0);
		// quotient >= 2^RATIO_W exactly when the top part already reaches the divisor
		flags_d.sat   = num_hi >= dvs_ext;
	end

	logic [RW-1:0]      rem_c   [0:RATIO_W];
	logic [RW-1:0]      dvs_c   [0:RATIO_W];
	logic [RATIO_W-1:0] low_c   [0:RATIO_W];
	logic [RATIO_W-1:0] quo_c   [0:RATIO_W];
	div_flags_t         flags_c [0:RATIO_W];
	logic               valid_c [0:RATIO_W];

	logic               valid_s4;
	logic [RW-1:0]      rem_s4, dvs_s4;
	logic [RATIO_W-1:0] low_s4;
	div_flags_t         flags_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4   <= num_hi[RW-1:0];
			dvs_s4   <= unsigned'(uni_in);
			low_s4   <= num[RATIO_W-1:0];
			flags_s4 <= flags_d;
		end
	end

	assign valid_c[0] = valid_s4;
	assign rem_c[0]   = rem_s4;
	assign dvs_c[0]   = dvs_s4;
	assign low_c[0]   = low_s4;
	assign quo_c[0]   = '0;
	assign flags_c[0] = flags_s4;

	for (genvar k = 0; k < RATIO_W; k++) begin : g_step
		biou_div_step #(
			.RW(RW)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_c[k]),
			.rem_in   (rem_c[k]),
			.dvs_in   (dvs_c[k]),
			.low_in   (low_c[k]),
			.quo_in   (quo_c[k]),
			.flags_in (flags_c[k]),
			.valid_sn (valid_c[k+1]),
			.rem_sn   (rem_c[k+1]),
			.dvs_sn   (dvs_c[k+1]),
			.low_sn   (low_c[k+1]),
			.quo_sn   (quo_c[k+1]),
			.flags_sn (flags_c[k+1])
		);
	end

	assign valid_out = valid_c[RATIO_W];

	always_comb begin
		result.empty_union = flags_c[RATIO_W].empty;
		if (flags_c[RATIO_W].empty) begin
			result.overlap_ratio = '0;
		end else if (flags_c[RATIO_W].sat) begin
			result.overlap_ratio = RATIO_MAX;
		end else begin
			result.overlap_ratio = quo_c[RATIO_W];
		end
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for box_iou_pairwise_core: pairs of boxes go in, IoU words come out.
// Expected IoU words are computed by an in-bench integer model and checked in arrival order.
// Depends on biou_pkg and box_iou_pairwise_core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import biou_pkg::*;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      box_valid = 1'b0;
	logic      box_stall;
	box_word_t box       = '0;
	logic      iou_valid;
	logic      iou_stall = 1'b0;
	iou_word_t iou;

	iou_word_t expected_iou[$];
	int        gap_pct;
	int        stall_pct;
	int        pairs_sent;
	int        results_checked;
	int        mismatches;

	box_iou_pairwise_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.box_valid(box_valid),
		.box_stall(box_stall),
		.box      (box),
		.iou_valid(iou_valid),
		.iou_stall(iou_stall),
		.iou      (iou)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Exact integer IoU: signed areas, clamped intersection, floor of inter*2^16/union.
	function automatic iou_word_t predict_overlap(input box_word_t w);
		longint at, al, ab, ar, bt, bl, bb, br;
		longint ih, iw, area_a, area_b, inter, uni;
		longint unsigned quot;
		iou_word_t r;
		at = longint'(w.a_top);
		al = longint'(w.a_left);
		ab = longint'(w.a_bottom);
		ar = longint'(w.a_right);
		bt = longint'(w.b_top);
		bl = longint'(w.b_left);
		bb = longint'(w.b_bottom);
		br = longint'(w.b_right);
		area_a = (ab - at) * (ar - al);
		area_b = (bb - bt) * (br - bl);
		ih = ((ab < bb) ? ab : bb) - ((at > bt) ? at : bt);
		iw = ((ar < br) ? ar : br) - ((al > bl) ? al : bl);
		if (ih < 0) ih = 0;
		if (iw < 0) iw = 0;
		inter = ih * iw;
		uni = area_a + area_b - inter;
		if (uni <= 0) begin
			r.overlap_ratio = '0;
			r.empty_union   = 1'b1;
		end else begin
			quot = unsigned'(inter <<< RATIO_W) / unsigned'(uni);
			r.overlap_ratio = (quot > 64'(RATIO_MAX)) ? RATIO_MAX : quot[RATIO_W-1:0];
			r.empty_union   = 1'b0;
		end
		return r;
	endfunction

	function automatic coord_t sat_coord(input int v);
		if (v > 32767) return coord_t'(32767);
		if (v < -32768) return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	function automatic box_word_t make_pair(input int at, al, ab, ar, bt, bl, bb, br);
		box_word_t w;
		w.a_top    = sat_coord(at);
		w.a_left   = sat_coord(al);
		w.a_bottom = sat_coord(ab);
		w.a_right  = sat_coord(ar);
		w.b_top    = sat_coord(bt);
		w.b_left   = sat_coord(bl);
		w.b_bottom = sat_coord(bb);
		w.b_right  = sat_coord(br);
		return w;
	endfunction

	// mostly small boxes, now and then one spanning the whole coordinate range
	function automatic int pick_extent();
		return ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 65535))
		                                   : int'($urandom_range(0, 512));
	endfunction

	// Called at a rising edge; returns at the rising edge that takes the word.
	task automatic send_pair(input box_word_t w);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			box_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		box       <= w;
		box_valid <= 1'b1;
		do @(negedge clk); while (box_stall);
		expected_iou.push_back(predict_overlap(w));
		pairs_sent++;
		@(posedge clk);
	endtask

	// Receiver stall, redrawn every cycle.
	always @(posedge clk)
		iou_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

	// Outputs are sampled mid-cycle; a word seen valid and unstalled here is taken at the next edge.
	always @(negedge clk) begin
		iou_word_t want;
		if (arst_n && iou_valid && !iou_stall) begin
			if (expected_iou.size() == 0) begin
				$error("unexpected IoU word: overlap_ratio %0d empty_union %0d",
				       iou.overlap_ratio, iou.empty_union);
				mismatches++;
			end else begin
				want = expected_iou.pop_front();
				results_checked++;
				if (iou.overlap_ratio !== want.overlap_ratio) begin
					$error("overlap_ratio expected %0d got %0d", want.overlap_ratio,
					       iou.overlap_ratio);
					mismatches++;
				end
				if (iou.empty_union !== want.empty_union) begin
					$error("empty_union expected %0d got %0d", want.empty_union,
					       iou.empty_union);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed_cases();
		send_pair(make_pair(0, 0, 16, 16, 0, 0, 16, 16));		// identical: saturates
		send_pair(make_pair(0, 0, 16, 16, 32, 32, 48, 48));		// disjoint
		send_pair(make_pair(0, 0, 16, 16, 16, 0, 32, 16));		// shared edge only
		send_pair(make_pair(0, 0, 32, 32, 16, 0, 48, 32));		// half overlap
		send_pair(make_pair(0, 0, 64, 64, 16, 16, 32, 32));		// B inside A
		send_pair(make_pair(0, 0, 100, 100, 0, 0, 100, 99));	// just under one
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));			// zero union
		send_pair(make_pair(5, 5, 5, 40, 0, 0, 16, 16));		// flat A
		send_pair(make_pair(16, 0, 0, 16, 0, 0, 32, 32));		// A inverted in y
		send_pair(make_pair(16, 0, 0, 16, 32, 0, 0, 32));		// both inverted: negative union
		send_pair(make_pair(-32768, -32768, 32767, 32767,
		                    -32768, -32768, 32767, 32767));
		send_pair(make_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
		send_pair(make_pair(32767, 32767, -32768, -32768,
		                    -32768, -32768, 32767, 32767));		// doubly inverted, positive area
		send_pair(make_pair(32767, -32768, -32768, 32767, 0, 0, 16, 16));
		send_pair(make_pair(-32768, -32768, -32768, -32768,
		                    -32768, -32768, -32768, -32768));
		send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		send_pair({8{16'h5555}});
		send_pair({8{16'hAAAA}});
		send_pair({4{16'h5555, 16'hAAAA}});
	endtask

	// Sensible boxes placed so that most pairs overlap, with a few inverted or identical.
	task automatic test_overlapping_pairs(input int count);
		int ay, ax, ah, aw, by, bx, bh, bw;
		repeat (count) begin
			ah = pick_extent();
			aw = pick_extent();
			ay = int'($urandom_range(0, 65535)) - 32768;
			ax = int'($urandom_range(0, 65535)) - 32768;
			bh = pick_extent();
			bw = pick_extent();
			by = ay + int'($urandom_range(0, ah + bh)) - bh;
			bx = ax + int'($urandom_range(0, aw + bw)) - bw;
			if ($urandom_range(0, 9) == 0) begin
				by = ay; bx = ax; bh = ah; bw = aw;
			end
			if ($urandom_range(0, 19) == 0) begin
				by = by + bh; bh = -bh;
			end
			send_pair(make_pair(ay, ax, ay + ah, ax + aw, by, bx, by + bh, bx + bw));
		end
	endtask

	// Unrestricted field values: every bit toggles, inverted boxes are common.
	task automatic test_raw_fields(input int count);
		box_word_t w;
		repeat (count) begin
			w = {$urandom, $urandom, $urandom, $urandom};
			send_pair(w);
		end
	endtask

	// Sender holds off until the core has handed back every pending word.
	task automatic test_drain_pause();
		box_valid <= 1'b0;
		while (expected_iou.size() != 0) @(posedge clk);
	endtask

	initial begin
		gap_pct   = 38;
		stall_pct = 49;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_overlapping_pairs(70);
		test_raw_fields(60);
		test_drain_pause();

		gap_pct   = 49;
		stall_pct = 38;
		test_overlapping_pairs(70);
		test_raw_fields(60);
		test_drain_pause();

		gap_pct   = 0;
		stall_pct = 0;
		test_overlapping_pairs(70);
		test_raw_fields(60);
		test_drain_pause();

		repeat (25) @(posedge clk);
		$display("%0d box pairs sent, %0d IoU words checked", pairs_sent, results_checked);
		$display("covered corner boxes, overlapping and random pairs under three pacing modes");
		if (mismatches == 0 && expected_iou.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule
